// File: design/fps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fps_pkg: shared types and constants of the fitness-proportional selector
// Field widths, operation codes, register map and sequencer states.
// ----------------------------------------------------------------------------
package fps_pkg;

  // stream field widths
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 6;
  localparam int DATA_W   = 32;   // fitness value and random fraction
  localparam int IDX_W    = 6;    // chosen_index
  localparam int IN_TDATA_W  = 72; // slot + fitness + fraction, byte padded
  localparam int OUT_TDATA_W = 8;  // chosen_index, byte padded

  // shared multiplier
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // configuration
  localparam int POP_W    = 7;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic [PADDR_W-1:0] REG_POP_SIZE = 3'd0;
  localparam logic [POP_W-1:0]   POP_RESET    = 7'd64;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
  localparam logic [OP_W-1:0] OP_ROULETTE = 2'd1;
  localparam logic [OP_W-1:0] OP_SUS      = 2'd2;

  // sequencer states, one-hot
  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_SUM  = 11'b000_0000_0010,
    ST_CHK  = 11'b000_0000_0100,
    ST_MLO  = 11'b000_0000_1000,
    ST_MHI  = 11'b000_0001_0000,
    ST_RD   = 11'b000_0010_0000,
    ST_RACC = 11'b000_0100_0000,
    ST_SMUL = 11'b000_1000_0000,
    ST_SACC = 11'b001_0000_0000,
    ST_SCMP = 11'b010_0000_0000,
    ST_ZOUT = 11'b100_0000_0000
  } state_t;

endpackage
`default_nettype wire

// File: design/fitness_proportional_selector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fitness_proportional_selector: roulette wheel and stochastic universal
// sampling selection engine for a genetic algorithm
// ----------------------------------------------------------------------------
// Input stream (s_*): tuser carries the operation (load, roulette, SUS),
// tdata carries slot, fitness value and a 0.32 random fraction.
// Output stream (m_*): tdata carries chosen_index, tlast marks the final
// index of a selection run, tuser flags a zero fitness total.
// APB port: register 0 (byte address 0) is population_size, reset 64.
// Sequence: a load writes its fitness slot and gives no transfer out. A
// select first sums slots 0..N-1 through the fitness memory read port, then
// forms r*total on the shared 32x32 multiplier (low word, then high word),
// then scans: roulette passes through RD and RACC per slot scanned, SUS
// through RD, SMUL, SACC and SCMP per slot, staying in SCMP per emitted index.
// The memory read port and the shared multiplier set this sequence.
// s_tready is high only while the sequencer is idle. Results go through a
// single output register: when the receiver stalls, the sequencer holds
// until the register drains; a finished result may wait while a new item
// is accepted. Reset clears control state, the output valid flag and
// population_size; fitness slots hold garbage until loaded.
// ----------------------------------------------------------------------------
module fitness_proportional_selector #(
  parameter int MAX_POPULATION = 64,
  parameter int FITNESS_BITS   = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // [5:0] slot, [37:6] fitness_value, [69:38] random_fraction, [71:70] zero
  input  wire logic [fps_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [1:0] operation
  input  wire logic [fps_pkg::OP_W-1:0]           s_tuser,
  // output stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [5:0] chosen_index, [7:6] zero
  output logic      [fps_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                    m_tlast,
  // [0] zero_total
  output logic      [0:0]                         m_tuser,
  // APB configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [fps_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [fps_pkg::PDATA_W-1:0]        pwdata,
  output logic      [fps_pkg::PDATA_W-1:0]        prdata,
  output logic                                    pready
);

  // stored fitness width, address, count, total and product widths
  localparam int FW = (FITNESS_BITS < fps_pkg::DATA_W) ? FITNESS_BITS : fps_pkg::DATA_W;
  localparam int AW = $clog2(MAX_POPULATION);
  localparam int NW = $clog2(MAX_POPULATION + 1);
  localparam int TW = FW + AW;
  localparam int MW = TW + NW;

  // input field unpack
  logic [fps_pkg::SLOT_W-1:0] in_slot;
  logic [fps_pkg::DATA_W-1:0] in_fitness;
  logic [fps_pkg::DATA_W-1:0] in_fraction;
  logic                       in_xfer;

  assign in_slot     = s_tdata[5:0];
  assign in_fitness  = s_tdata[37:6];
  assign in_fraction = s_tdata[69:38];
  assign in_xfer     = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  logic [fps_pkg::POP_W-1:0] pop_size;
  logic                      pop_wr;

  assign pready = 1'b1;
  assign pop_wr = psel && penable && pwrite && pready && (paddr == fps_pkg::REG_POP_SIZE);
  assign prdata = (paddr == fps_pkg::REG_POP_SIZE) ? fps_pkg::PDATA_W'(pop_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_size <= fps_pkg::POP_RESET;
    end else if (pop_wr) begin
      pop_size <= pwdata[fps_pkg::POP_W-1:0];
    end
  end

  // effective population, clamped to 1..MAX_POPULATION
  logic [NW-1:0] n_sel;

  always_comb begin
    if (pop_size == '0) begin
      n_sel = NW'(1);
    end else if (32'(pop_size) > MAX_POPULATION) begin
      n_sel = NW'(MAX_POPULATION);
    end else begin
      n_sel = NW'(pop_size);
    end
  end

  // ---------------------------------------------------------------------------
  // fitness memory: one write port (loads), one registered read port (sum and scan)
  // ---------------------------------------------------------------------------
  logic [FW-1:0] fit_mem [MAX_POPULATION];
  logic [FW-1:0] rdata;
  logic [AW-1:0] rd_addr;
  logic          mem_wr;

  fps_pkg::state_t state;

  assign mem_wr = in_xfer && (s_tuser == fps_pkg::OP_LOAD) &&
                  (32'(in_slot) < MAX_POPULATION);

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      fit_mem[AW'(in_slot)] <= in_fitness[FW-1:0];
    end
    rdata <= fit_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // sequencer registers
  // ---------------------------------------------------------------------------
  logic                       sus;       // current run is SUS
  logic [fps_pkg::DATA_W-1:0] frac;      // latched random fraction
  logic [NW-1:0]              n;         // population of this run
  logic [NW-1:0]              idx;       // scan / sum slot
  logic [NW-1:0]              k;         // SUS pointer count
  logic                       rd_vld;    // rdata holds a slot for the sum
  logic [TW-1:0]              total;
  logic [TW-1:0]              cum;       // roulette running sum
  logic [TW-1:0]              ph;        // floor(r*total / 2^32)
  logic                       pl_nz;     // low word of r*total nonzero
  logic [MW-1:0]              acc_a;     // SUS: cum * n
  logic [MW-1:0]              acc_b;     // SUS: k * total + ph

  assign rd_addr = idx[AW-1:0];

  // ---------------------------------------------------------------------------
  // shared multiplier: r*total low word, r*total high word, fitness*n
  // ---------------------------------------------------------------------------
  logic [fps_pkg::MUL_W-1:0]  mul_a;
  logic [fps_pkg::MUL_W-1:0]  mul_b;
  logic [fps_pkg::PROD_W-1:0] prod;
  logic [fps_pkg::PROD_W-1:0] total_ext;

  assign total_ext = fps_pkg::PROD_W'(total);

  always_comb begin
    unique case (state)
      fps_pkg::ST_MLO: begin
        mul_a = frac;
        mul_b = total_ext[2*fps_pkg::MUL_W-1:fps_pkg::MUL_W];
      end
      fps_pkg::ST_SMUL: begin
        mul_a = fps_pkg::MUL_W'(rdata);
        mul_b = fps_pkg::MUL_W'(n);
      end
      default: begin
        mul_a = frac;
        mul_b = total_ext[fps_pkg::MUL_W-1:0];
      end
    endcase
  end

  fps_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // ---------------------------------------------------------------------------
  // compares
  // ---------------------------------------------------------------------------
  logic [TW-1:0] cum_next;
  logic [TW-1:0] ph_sum;
  logic [NW-1:0] n_m1;
  logic          r_hit;
  logic          at_end;
  logic          a_gt_b;
  logic          k_done;

  assign cum_next = cum + TW'(rdata);
  assign ph_sum   = ph + TW'(prod);
  assign n_m1     = n - NW'(1);
  // cum * 2^32 >= r * total
  assign r_hit    = (cum_next > ph) || ((cum_next == ph) && !pl_nz);
  assign at_end   = (idx == n_m1);
  // cum * n * 2^32 > (r + k * 2^32) * total reduces to cum * n > k * total + ph
  assign a_gt_b   = acc_a > acc_b;
  assign k_done   = (k == n);

  // ---------------------------------------------------------------------------
  // result emission into the output register
  // ---------------------------------------------------------------------------
  logic                      out_free;
  logic                      emit;
  logic [fps_pkg::IDX_W-1:0] emit_idx;
  logic                      emit_last;
  logic                      emit_zero;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    emit      = 1'b0;
    emit_idx  = fps_pkg::IDX_W'(idx);
    emit_last = 1'b1;
    emit_zero = 1'b0;
    unique case (state)
      fps_pkg::ST_ZOUT: begin
        emit      = out_free;
        emit_idx  = '0;
        emit_zero = 1'b1;
      end
      fps_pkg::ST_RACC: begin
        emit = out_free && (r_hit || at_end);
      end
      fps_pkg::ST_SCMP: begin
        emit      = out_free && !k_done && (a_gt_b || at_end);
        emit_last = (k == n_m1);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata    <= fps_pkg::OUT_TDATA_W'(emit_idx);
      m_tlast    <= emit_last;
      m_tuser[0] <= emit_zero;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign s_tready = (state == fps_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= fps_pkg::ST_IDLE;
      rd_vld <= 1'b0;
      idx    <= '0;
      k      <= '0;
    end else begin
      unique case (state)
        fps_pkg::ST_IDLE: begin
          if (in_xfer && ((s_tuser == fps_pkg::OP_ROULETTE) ||
                          (s_tuser == fps_pkg::OP_SUS))) begin
            sus    <= (s_tuser == fps_pkg::OP_SUS);
            frac   <= in_fraction;
            n      <= n_sel;
            idx    <= '0;
            total  <= '0;
            rd_vld <= 1'b0;
            state  <= fps_pkg::ST_SUM;
          end
        end
        // total of slots 0..n-1, one read per cycle
        fps_pkg::ST_SUM: begin
          if (rd_vld) begin
            total <= total + TW'(rdata);
          end
          if (idx != n) begin
            idx    <= idx + NW'(1);
            rd_vld <= 1'b1;
          end else begin
            rd_vld <= 1'b0;
            if (!rd_vld) begin
              state <= fps_pkg::ST_CHK;
            end
          end
        end
        fps_pkg::ST_CHK: begin
          state <= (total == '0) ? fps_pkg::ST_ZOUT : fps_pkg::ST_MLO;
        end
        fps_pkg::ST_ZOUT: begin
          if (out_free) begin
            state <= fps_pkg::ST_IDLE;
          end
        end
        // prod = r * total[31:0]
        fps_pkg::ST_MLO: begin
          ph    <= TW'(prod[fps_pkg::PROD_W-1:fps_pkg::MUL_W]);
          pl_nz <= |prod[fps_pkg::MUL_W-1:0];
          state <= fps_pkg::ST_MHI;
        end
        // prod = r * total[63:32]
        fps_pkg::ST_MHI: begin
          ph    <= ph_sum;
          acc_b <= MW'(ph_sum);
          acc_a <= '0;
          cum   <= '0;
          idx   <= '0;
          k     <= '0;
          state <= fps_pkg::ST_RD;
        end
        fps_pkg::ST_RD: begin
          state <= sus ? fps_pkg::ST_SMUL : fps_pkg::ST_RACC;
        end
        fps_pkg::ST_RACC: begin
          if (r_hit || at_end) begin
            if (out_free) begin
              state <= fps_pkg::ST_IDLE;
            end
          end else begin
            cum   <= cum_next;
            idx   <= idx + NW'(1);
            state <= fps_pkg::ST_RD;
          end
        end
        fps_pkg::ST_SMUL: begin
          state <= fps_pkg::ST_SACC;
        end
        fps_pkg::ST_SACC: begin
          acc_a <= acc_a + MW'(prod);
          state <= fps_pkg::ST_SCMP;
        end
        // emit this slot for every pointer it passes; past the end, clamp
        fps_pkg::ST_SCMP: begin
          if (k_done) begin
            state <= fps_pkg::ST_IDLE;
          end else if (a_gt_b || at_end) begin
            if (out_free) begin
              k     <= k + NW'(1);
              acc_b <= acc_b + MW'(total);
            end
          end else begin
            idx   <= idx + NW'(1);
            state <= fps_pkg::ST_RD;
          end
        end
        default: begin
          state <= fps_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/fps_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fps_mul: shared 32x32 unsigned multiplier
// One registered product per cycle; operands are steered by the sequencer.
// ----------------------------------------------------------------------------
module fps_mul (
  input  wire logic                        clk,
  input  wire logic [fps_pkg::MUL_W-1:0]   a,
  input  wire logic [fps_pkg::MUL_W-1:0]   b,
  output logic      [fps_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= fps_pkg::PROD_W'(a) * fps_pkg::PROD_W'(b);
  end

endmodule
`default_nettype wire

// File: sim/fitness_proportional_selector_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitness_proportional_selector_checker: selection predictor and result check
// Tracks loads and population_size writes, predicts the indices each
// roulette or SUS transfer must produce and compares every output transfer.
// ----------------------------------------------------------------------------
module fitness_proportional_selector_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  // [5:0] slot, [37:6] fitness_value, [69:38] random_fraction, [71:70] zero
  input  logic [fps_pkg::IN_TDATA_W-1:0]   s_tdata,
  // [1:0] operation
  input  logic [fps_pkg::OP_W-1:0]         s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  // [5:0] chosen_index, [7:6] zero
  input  logic [fps_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                             m_tlast,
  // [0] zero_total
  input  logic [0:0]                       m_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [fps_pkg::PADDR_W-1:0]      paddr,
  input  logic [fps_pkg::PDATA_W-1:0]      pwdata,
  output int                               mismatches,
  output int                               outstanding
);
  import fps_pkg::*;

  localparam int MAX_SLOTS = 64;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
    logic             zero_total;
  } pick_t;

  pick_t             picks_due[$];
  logic [DATA_W-1:0] fitness_mem [MAX_SLOTS];
  logic [POP_W-1:0]  pop_setting = POP_RESET;

  // Works out the picks of one roulette or SUS transfer, all in 128-bit math.
  function automatic void predict_picks(input logic [OP_W-1:0] op,
                                        input logic [DATA_W-1:0] frac);
    int         n;
    int         k;
    int         pick;
    bit [127:0] total;
    bit [127:0] cum;
    bit [127:0] lhs;
    bit [127:0] rhs;
    n = (pop_setting == 0) ? 1 : (pop_setting > MAX_SLOTS) ? MAX_SLOTS : pop_setting;
    total = '0;
    for (int i = 0; i < n; i++) total += 128'(fitness_mem[i]);
    if (total == 0) begin
      picks_due.push_back({IDX_W'(0), 1'b1, 1'b1});
      return;
    end
    cum = '0;
    if (op == OP_ROULETTE) begin
      pick = n - 1;
      rhs = 128'(frac) * total;
      for (int i = 0; i < n; i++) begin
        cum += 128'(fitness_mem[i]);
        lhs = cum << 32;
        if (lhs >= rhs) begin
          pick = i;
          break;
        end
      end
      picks_due.push_back({IDX_W'(pick), 1'b1, 1'b0});
    end else begin
      k = 0;
      for (int i = 0; i < n && k < n; i++) begin
        cum += 128'(fitness_mem[i]);
        lhs = (cum * 128'(n)) << 32;
        while (k < n) begin
          rhs = (128'(frac) + (128'(k) << 32)) * total;
          if (lhs <= rhs) break;
          picks_due.push_back({IDX_W'(i), k == n - 1, 1'b0});
          k++;
        end
      end
      // pointers left over fall on the last slot
      while (k < n) begin
        picks_due.push_back({IDX_W'(n - 1), k == n - 1, 1'b0});
        k++;
      end
    end
  endfunction

  always @(posedge clk) begin
    pick_t seen;
    pick_t want;
    if (rst) begin
      picks_due.delete();
      pop_setting = POP_RESET;
      mismatches = 0;
    end else begin
      // results first: a transfer out always belongs to an earlier input
      if (m_tvalid && m_tready) begin
        seen = {m_tdata[IDX_W-1:0], m_tlast, m_tuser[0]};
        if (picks_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: index %0d last %0b zero_total %0b",
                     $realtime, seen.index, seen.last, seen.zero_total);
        end else begin
          want = picks_due.pop_front();
          if (want.index != seen.index || want.last != seen.last ||
              want.zero_total != seen.zero_total) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] mismatch: expected index %0d last %0b zero_total %0b,",
                       $realtime, want.index, want.last, want.zero_total);
              $display("  got index %0d last %0b zero_total %0b",
                       seen.index, seen.last, seen.zero_total);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          OP_LOAD: fitness_mem[s_tdata[SLOT_W-1:0]] = s_tdata[SLOT_W +: DATA_W];
          OP_ROULETTE, OP_SUS: predict_picks(s_tuser, s_tdata[SLOT_W+DATA_W +: DATA_W]);
          default: ;
        endcase
      end
      if (psel && penable && pwrite && pready && paddr == REG_POP_SIZE)
        pop_setting = pwdata[POP_W-1:0];
    end
    outstanding <= picks_due.size();
  end

endmodule

// File: sim/fitness_proportional_selector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitness_proportional_selector_test: stimulus and verdict for the selector
// Drives load, roulette and SUS transfers plus population_size writes, with
// random idle gaps on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module fitness_proportional_selector_test;
  import fps_pkg::*;

  // operation 3 has no meaning; the block must drop it silently
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int MAX_SLOTS   = 64;
  localparam int ITEM_TARGET = 430;      // counted input transfers
  localparam int PHASE_ITEMS = 40;       // transfers per population setting
  localparam int LONG_HOLD   = 400;      // receiver hold-off, in cycles
  localparam int SETTLE      = 16;       // quiet cycles after last result
  localparam int CYCLE_LIMIT = 10_000_000;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // [5:0] slot, [37:6] fitness_value, [69:38] random_fraction, [71:70] zero
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  // [1:0] operation
  logic [OP_W-1:0]        s_tuser  = OP_LOAD;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // [5:0] chosen_index, [7:6] zero
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  // [0] zero_total
  logic [0:0]             m_tuser;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [PADDR_W-1:0]     paddr    = '0;
  logic [PDATA_W-1:0]     pwdata   = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int items_sent  = 0;
  bit quiet       = 1'b0;   // no idling on either side while set
  bit long_hold   = 1'b0;   // asks the receiver for one long hold-off

  fitness_proportional_selector dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  fitness_proportional_selector_checker selection_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs or drops results
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL fitness_proportional_selector");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Zero, all ones and small values show up often so that totals hit zero,
  // overflow 32 bits and land on exact pointer boundaries.
  function automatic logic [DATA_W-1:0] random_fitness(input bit zero_heavy);
    int roll;
    roll = $urandom_range(0, 19);
    if (zero_heavy && roll < 14) return '0;
    if (roll < 2) return '0;
    if (roll < 5) return '1;
    if (roll < 10) return DATA_W'($urandom_range(0, 15));
    return $urandom;
  endfunction

  // One input transfer; s_tvalid stays high across back-to-back transfers.
  task automatic send_item(input logic [OP_W-1:0]   op,
                           input logic [SLOT_W-1:0] slot,
                           input logic [DATA_W-1:0] fitness,
                           input logic [DATA_W-1:0] frac);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, frac, fitness, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Wait until every predicted result has left the block, then let the
  // sequencer finish whatever it still has in flight.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic set_population(input logic [POP_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_POP_SIZE;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random ready runs and gaps, plus one long hold-off on request
  // so the output register backs up into the input side.
  initial begin
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    int               ph;
    int               n;
    int               roll;
    bit               zero_heavy;
    logic [POP_W-1:0] setting;
    logic [OP_W-1:0]  op;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] frac;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part ---------------------------------------------------
    // population_size 0 must behave as a single slot
    set_population('0);
    send_item(OP_UNUSED, SLOT_W'($urandom), $urandom, $urandom);
    send_item(OP_LOAD, 6'd0, '0, '0);
    send_item(OP_ROULETTE, 6'd0, '0, '0);       // zero total
    send_item(OP_SUS, 6'd0, '0, '1);            // zero total, one result only
    send_item(OP_LOAD, 6'd0, '1, '0);
    send_item(OP_ROULETTE, 6'd0, '0, '1);
    send_item(OP_SUS, 6'd0, '0, '0);
    send_item(OP_LOAD, 6'd63, '1, '0);          // outside the active slots
    send_item(OP_LOAD, 6'd1, 32'd5, '0);
    send_item(OP_LOAD, 6'd2, '0, '0);
    send_item(OP_LOAD, 6'd3, 32'd7, '0);
    send_item(OP_LOAD, 6'd0, 32'd3, '0);        // overwrite, total must follow
    settle();

    // four slots 3, 5, 0, 7: pointers fall on both sides of the empty slot
    set_population(7'd4);
    send_item(OP_ROULETTE, 6'd0, '0, '0);
    send_item(OP_ROULETTE, 6'd0, '0, '1);
    send_item(OP_ROULETTE, 6'd0, '0, 32'h8000_0000);
    send_item(OP_SUS, 6'd0, '0, '0);
    send_item(OP_SUS, 6'd0, '0, '1);
    send_item(OP_LOAD, 6'd3, '1, '0);
    send_item(OP_SUS, 6'd0, '0, 32'h4000_0000);
    send_item(OP_LOAD, 6'd0, '0, '0);
    send_item(OP_LOAD, 6'd1, '0, '0);
    send_item(OP_ROULETTE, 6'd0, '0, $urandom); // leading empty slots
    send_item(OP_UNUSED, SLOT_W'($urandom), $urandom, $urandom);
    settle();

    // --- random part -----------------------------------------------------
    // every slot gets a value first, so any population size is legal
    for (int s = 0; s < MAX_SLOTS; s++)
      send_item(OP_LOAD, SLOT_W'(s), random_fitness(1'b0), $urandom);

    ph = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      case (ph)
        0: setting = 7'd64;
        1: setting = 7'd1;
        2: setting = 7'd127;                   // clamps to the maximum
        3: setting = 7'd2;
        4: setting = 7'd0;
        default: begin
          if ($urandom_range(0, 3) == 0) setting = POP_W'($urandom_range(65, 127));
          else setting = POP_W'($urandom_range(1, MAX_SLOTS));
        end
      endcase
      set_population(setting);
      n = (setting == 0) ? 1 : (setting > MAX_SLOTS) ? MAX_SLOTS : setting;
      quiet      = (ph != 0) && ($urandom_range(0, 3) == 0);
      zero_heavy = (ph == 3) || ($urandom_range(0, 4) == 0);
      // full population with SUS fills the output path during the hold-off
      if (ph == 0) long_hold = 1'b1;

      for (int j = 0; j < PHASE_ITEMS && items_sent < ITEM_TARGET; j++) begin
        roll = $urandom_range(0, 19);
        if (roll < 8) op = OP_LOAD;
        else if (roll < 13) op = OP_ROULETTE;
        else if (roll < 19) op = OP_SUS;
        else op = OP_UNUSED;
        // loads mostly hit the active slots so the selections keep changing
        if ($urandom_range(0, 9) < 7) slot = SLOT_W'($urandom_range(0, n - 1));
        else slot = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
        roll = $urandom_range(0, 9);
        if (roll == 0) frac = '0;
        else if (roll == 1) frac = '1;
        else frac = $urandom;
        send_item(op, slot, random_fitness(zero_heavy), frac);
      end
      ph++;
    end

    quiet = 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("PASS fitness_proportional_selector");
    end else begin
      $display("FAIL fitness_proportional_selector");
    end
    $finish;
  end

endmodule
